### hw/rtl/sclut_pkg.sv
// shared types, constants and helpers of the striped color lut interpolator
package sclut_pkg;

  // table geometry
  localparam int NumTablesDef = 6;
  localparam int CurveEntries = 256;
  localparam int KeyW         = $clog2(CurveEntries);
  localparam int ValW         = 8;
  localparam int TableW       = 3;
  localparam int ChanW        = 2;
  localparam int CoordW       = 10;
  localparam int NumChan      = 3;

  // channel lanes
  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;

  // anchor layout of a curve
  localparam int AnchorStep  = 4;
  localparam int StepW       = $clog2(AnchorStep);
  localparam int SegW        = KeyW - StepW;
  localparam int FirstAnchor = 1;
  localparam int LastAnchor  = 253;
  localparam int LastSeg     = (LastAnchor - FirstAnchor) / AnchorStep - 1;

  // queue between front and back
  localparam int QueueDepth = 2;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;
  localparam logic [CoordW-1:0] StripeWidthRst  = CoordW'(100);
  localparam logic [CoordW-1:0] StripeHeightRst = CoordW'(75);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STRIPE_WIDTH  = 1'b0,
    CFG_STRIPE_HEIGHT = 1'b1
  } cfg_reg_e;

  // item kinds
  typedef enum logic [1:0] {
    OP_ANCHOR = 2'd0,
    OP_FILL   = 2'd1,
    OP_PIXEL  = 2'd2
  } op_e;

  // back end sequencer
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PIX_S1,
    BK_PIX_S2,
    BK_FILL_START,
    BK_FILL_A,
    BK_FILL_RD,
    BK_FILL_W1,
    BK_FILL_W2,
    BK_FILL_W3,
    BK_FILL_T1,
    BK_FILL_T2
  } back_state_e;

  // stripe decode of one coordinate
  typedef struct packed {
    logic              ok;
    logic [TableW-1:0] tab;
  } stripe_t;

  // classified item handed from front to back
  typedef struct packed {
    op_e                             op;
    logic [TableW-1:0]               table_idx;
    logic [ChanW-1:0]                chan;
    logic [KeyW-1:0]                 key;
    logic [ValW-1:0]                 value;
    logic                            col_ok;
    logic [TableW-1:0]               col_tab;
    logic                            row_ok;
    logic [TableW-1:0]               row_tab;
    logic [NumChan-1:0][ValW-1:0]    px;
  } sclut_op_t;

  // lo + m*(hi-lo)/4, division truncating toward zero
  function automatic logic [ValW-1:0] interp(input logic [ValW-1:0]  lo,
                                             input logic [ValW-1:0]  hi,
                                             input logic [StepW-1:0] m);
    logic signed [ValW:0]   diff;
    logic signed [ValW+2:0] mul;
    logic signed [ValW+2:0] prod;
    logic signed [ValW+2:0] quot;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    mul  = $signed({{(ValW + 3 - StepW){1'b0}}, m});
    prod = mul * (ValW+3)'(diff);
    quot = prod[ValW+2] ? ((prod + (ValW+3)'(AnchorStep - 1)) >>> StepW)
                        : (prod >>> StepW);
    return lo + quot[ValW-1:0];
  endfunction

endpackage

### hw/rtl/sclut_if.sv
// item and result channel interfaces of the striped color lut interpolator
interface sclut_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] table_sel;
  logic [1:0] channel_sel;
  logic [7:0] entry_key;
  logic [7:0] entry_value;
  logic [9:0] pixel_row;
  logic [9:0] pixel_col;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (
    output valid, kind, table_sel, channel_sel, entry_key, entry_value,
    output pixel_row, pixel_col, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, kind, table_sel, channel_sel, entry_key, entry_value,
    input  pixel_row, pixel_col, red_in, green_in, blue_in,
    output ready
  );
endinterface

interface sclut_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

### hw/rtl/sclut_front.sv
// front end: stripe registers, item accept and classification
module sclut_front import sclut_pkg::*; #(
  parameter int NUM_TABLES = NumTablesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sclut_item_if.sink          item_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sclut_op_t           q_data_o
);

  localparam int CntW  = $clog2(NUM_TABLES + 1);
  localparam int ProdW = CoordW + CntW;

  logic [CoordW-1:0] width_q;
  logic [CoordW-1:0] height_q;
  stripe_t           col_st;
  stripe_t           row_st;
  logic              keep;

  // stripe index by comparing against each stripe boundary
  function automatic stripe_t stripe_of(input logic [CoordW-1:0] coord,
                                        input logic [CoordW-1:0] size);
    stripe_t          res;
    logic [ProdW-1:0] lim;
    logic [CntW-1:0]  cnt;
    cnt = '0;
    for (int k = 1; k <= NUM_TABLES; k++) begin
      lim = ProdW'(k) * ProdW'(size);
      if (ProdW'(coord) >= lim) begin
        cnt = cnt + CntW'(1);
      end
    end
    res.ok  = (size != '0) && (cnt < CntW'(NUM_TABLES));
    res.tab = TableW'(cnt);
    return res;
  endfunction

  // stripe size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= StripeWidthRst;
      height_q <= StripeHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STRIPE_WIDTH:  width_q  <= CoordW'(cfg_data_i);
        CFG_STRIPE_HEIGHT: height_q <= CoordW'(cfg_data_i);
      endcase
    end
  end

  // accept whenever the queue has room
  assign item_i.ready = !q_full_i;

  // classify the beat and build the queue entry
  always_comb begin
    col_st = stripe_of(item_i.pixel_col, width_q);
    row_st = stripe_of(item_i.pixel_row, height_q);

    q_data_o.op        = op_e'(item_i.kind);
    q_data_o.table_idx = item_i.table_sel;
    q_data_o.chan      = item_i.channel_sel;
    q_data_o.key       = item_i.entry_key;
    q_data_o.value     = item_i.entry_value;
    q_data_o.col_ok    = col_st.ok;
    q_data_o.col_tab   = col_st.tab;
    q_data_o.row_ok    = row_st.ok;
    q_data_o.row_tab   = row_st.tab;
    q_data_o.px[ChRed]   = item_i.red_in;
    q_data_o.px[ChGreen] = item_i.green_in;
    q_data_o.px[ChBlue]  = item_i.blue_in;

    // bad anchor targets and the unused kind are dropped here
    unique case (item_i.kind) inside
      OP_ANCHOR:        keep = ({1'b0, item_i.table_sel} < (TableW+1)'(NUM_TABLES)) &&
                               (item_i.channel_sel < ChanW'(NumChan));
      OP_FILL, OP_PIXEL: keep = 1'b1;
      default:          keep = 1'b0;
    endcase

    q_push_o = item_i.valid && item_i.ready && keep;
  end

endmodule

### hw/rtl/sclut_queue.sv
// short queue of classified items between front and back
module sclut_queue import sclut_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sclut_op_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output sclut_op_t head_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  sclut_op_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // pointer and fill level update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];

endmodule

### hw/rtl/sclut_back.sv
// back end: curve memories, lookup and fill sequencer, result register
module sclut_back import sclut_pkg::*; #(
  parameter int NUM_TABLES = NumTablesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  sclut_op_t   q_head_i,
  output logic        q_pop_o,
  sclut_result_if.source result_o
);

  localparam int TabW  = $clog2(NUM_TABLES);
  localparam int AddrW = TabW + KeyW;
  localparam int Depth = NUM_TABLES * CurveEntries;

  back_state_e                  state_q, state_d;
  sclut_op_t                    op_q, op_d;
  logic [TabW-1:0]              tab_q, tab_d;
  logic [SegW-1:0]              seg_q, seg_d;
  logic [NumChan-1:0][ValW-1:0] anc_q, anc_d;
  logic [NumChan-1:0][ValW-1:0] px_q, px_d;
  logic                         res_valid_q, res_valid_d;
  logic [NumChan-1:0][ValW-1:0] res_q, res_d;

  logic [NumChan-1:0]            mem_we;
  logic [AddrW-1:0]              mem_waddr;
  logic [NumChan-1:0][ValW-1:0]  mem_wdata;
  logic                          mem_re;
  logic [NumChan-1:0][AddrW-1:0] mem_raddr;
  logic [NumChan-1:0][ValW-1:0]  mem_rdata;
  logic [NumChan-1:0][ValW-1:0]  s1_px;
  logic [NumChan-1:0][ValW-1:0]  s2_px;

  function automatic logic [AddrW-1:0] addr_of(input logic [TabW-1:0] t,
                                               input logic [KeyW-1:0] k);
    return {t, k};
  endfunction

  // one curve memory per color channel
  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    logic [ValW-1:0] mem_q [Depth];
    logic [ValW-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (mem_we[c]) begin
        mem_q[mem_waddr] <= mem_wdata[c];
      end
      if (mem_re) begin
        rd_q <= mem_q[mem_raddr[c]];
      end
    end

    assign mem_rdata[c] = rd_q;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    tab_d       = tab_q;
    seg_d       = seg_q;
    anc_d       = anc_q;
    px_d        = px_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !result_o.ready;
    q_pop_o     = 1'b0;
    mem_we      = '0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    for (int c = 0; c < NumChan; c++) begin
      s1_px[c] = op_q.col_ok ? mem_rdata[c] : op_q.px[c];
      s2_px[c] = op_q.row_ok ? mem_rdata[c] : px_q[c];
    end

    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_head_i.op)
            OP_ANCHOR: begin
              for (int c = 0; c < NumChan; c++) begin
                mem_we[c]    = (q_head_i.chan == ChanW'(c));
                mem_wdata[c] = q_head_i.value;
              end
              mem_waddr = addr_of(q_head_i.table_idx[TabW-1:0], q_head_i.key);
            end
            OP_PIXEL: begin
              op_d   = q_head_i;
              mem_re = 1'b1;
              for (int c = 0; c < NumChan; c++) begin
                mem_raddr[c] = addr_of(q_head_i.col_tab[TabW-1:0], q_head_i.px[c]);
              end
              state_d = BK_PIX_S1;
            end
            OP_FILL: begin
              tab_d   = '0;
              state_d = BK_FILL_START;
            end
            default: ;
          endcase
        end
      end

      // column stage done, start row stage lookup
      BK_PIX_S1: begin
        px_d   = s1_px;
        mem_re = 1'b1;
        for (int c = 0; c < NumChan; c++) begin
          mem_raddr[c] = addr_of(op_q.row_tab[TabW-1:0], s1_px[c]);
        end
        state_d = BK_PIX_S2;
      end

      // row stage done, hand over once the result register is free
      BK_PIX_S2: begin
        if (!res_valid_q || result_o.ready) begin
          res_d       = s2_px;
          res_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end

      BK_FILL_START: begin
        mem_re = 1'b1;
        for (int c = 0; c < NumChan; c++) begin
          mem_raddr[c] = addr_of(tab_q, KeyW'(FirstAnchor));
        end
        state_d = BK_FILL_A;
      end

      // first anchor also sets entry zero
      BK_FILL_A: begin
        anc_d     = mem_rdata;
        mem_we    = '1;
        mem_waddr = addr_of(tab_q, '0);
        mem_wdata = mem_rdata;
        seg_d     = '0;
        state_d   = BK_FILL_RD;
      end

      BK_FILL_RD: begin
        mem_re = 1'b1;
        for (int c = 0; c < NumChan; c++) begin
          mem_raddr[c] = addr_of(tab_q, {seg_q + SegW'(1), StepW'(1)});
        end
        state_d = BK_FILL_W1;
      end

      // three interpolated entries per segment, upper anchor held in read data
      BK_FILL_W1: begin
        mem_we    = '1;
        mem_waddr = addr_of(tab_q, {seg_q, StepW'(2)});
        for (int c = 0; c < NumChan; c++) begin
          mem_wdata[c] = interp(anc_q[c], mem_rdata[c], StepW'(1));
        end
        state_d = BK_FILL_W2;
      end

      BK_FILL_W2: begin
        mem_we    = '1;
        mem_waddr = addr_of(tab_q, {seg_q, StepW'(3)});
        for (int c = 0; c < NumChan; c++) begin
          mem_wdata[c] = interp(anc_q[c], mem_rdata[c], StepW'(2));
        end
        state_d = BK_FILL_W3;
      end

      BK_FILL_W3: begin
        mem_we    = '1;
        mem_waddr = addr_of(tab_q, {seg_q + SegW'(1), StepW'(0)});
        for (int c = 0; c < NumChan; c++) begin
          mem_wdata[c] = interp(anc_q[c], mem_rdata[c], StepW'(3));
        end
        anc_d = mem_rdata;
        if (seg_q == SegW'(LastSeg)) begin
          state_d = BK_FILL_T1;
        end else begin
          seg_d   = seg_q + SegW'(1);
          state_d = BK_FILL_RD;
        end
      end

      // tail entries copy the last anchor
      BK_FILL_T1: begin
        mem_we    = '1;
        mem_waddr = addr_of(tab_q, KeyW'(LastAnchor + 1));
        mem_wdata = anc_q;
        state_d   = BK_FILL_T2;
      end

      BK_FILL_T2: begin
        mem_we    = '1;
        mem_waddr = addr_of(tab_q, KeyW'(LastAnchor + 2));
        mem_wdata = anc_q;
        if (tab_q == TabW'(NUM_TABLES - 1)) begin
          state_d = BK_IDLE;
        end else begin
          tab_d   = tab_q + TabW'(1);
          state_d = BK_FILL_START;
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      tab_q       <= '0;
      seg_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tab_q       <= tab_d;
      seg_q       <= seg_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    anc_q <= anc_d;
    px_q  <= px_d;
    res_q <= res_d;
  end

  assign result_o.valid     = res_valid_q;
  assign result_o.red_out   = res_q[ChRed];
  assign result_o.green_out = res_q[ChGreen];
  assign result_o.blue_out  = res_q[ChBlue];

  // checks
  a_no_write_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_PIX_S1 || state_q == BK_PIX_S2) |-> (mem_we == '0))
    else $error("curve memory written during a pixel lookup");

  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == BK_PIX_S2))
    else $error("result beat raised outside the row stage");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (q_valid_i && state_q == BK_IDLE))
    else $error("queue popped while empty or busy");

  a_fill_table_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_IDLE) |-> ({1'b0, tab_q} < (TabW+1)'(NUM_TABLES)))
    else $error("fill table index out of range");

endmodule

### hw/rtl/striped_color_lut_interpolator_top.sv
// Striped color lut interpolator: two stripe-selected curve lookups per pixel.
// Pixel beat: dependent column then row read of the single-read-port channel memories, issued
// on leaving the queue and in BK_PIX_S1; BK_PIX_S2 loads the result register once it is free,
// and no new item leaves the queue until then. Anchor beat: one per cycle while the back end
// is idle. Fill beat: all tables in turn, one anchor read and three entry writes per segment.
// Input stays ready while the 2-entry queue has room.
// Reset clears control state and sets stripe sizes to 100 and 75; curve memories are not cleared.
module striped_color_lut_interpolator_top import sclut_pkg::*; #(
  parameter int NUM_TABLES = NumTablesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sclut_item_if.sink          item_i,
  sclut_result_if.source      result_o
);

  logic      q_push;
  sclut_op_t q_data;
  logic      q_full;
  logic      q_valid;
  sclut_op_t q_head;
  logic      q_pop;

  // accept and classify
  sclut_front #(
    .NUM_TABLES (NUM_TABLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_data)
  );

  // decoupling queue
  sclut_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // memories and execution
  sclut_back #(
    .NUM_TABLES (NUM_TABLES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

endmodule

### tb/tb_top.sv
// self-checking testbench of the striped color lut interpolator
`timescale 1ns / 100ps

module tb_top;
  import sclut_pkg::*;

  localparam int NumTables = NumTablesDef;
  // idle cycles that cover table rebuilds still queued or running in the block
  localparam int FillGuard = (QueueDepth + 1) * (NumTables * CurveEntries + 1) + 64;
  localparam int MaxReports = 10;
  localparam logic [1:0]       KIND_UNUSED = 2'd3;
  localparam logic [ChanW-1:0] CHAN_NONE   = 2'd3;

  typedef logic [NumChan-1:0][ValW-1:0] rgb_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TableW-1:0] table_sel;
    logic [ChanW-1:0]  chan;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    rgb_t              rgb;
  } beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sclut_item_if   item_bus ();
  sclut_result_if result_bus ();

  striped_color_lut_interpolator_top #(
    .NUM_TABLES(NumTables)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .item_i    (item_bus.sink),
    .result_o  (result_bus.source)
  );

  // shadow curve tables and stripe sizes
  logic [ValW-1:0]   curve_mem [NumTables][NumChan][CurveEntries];
  logic [CoordW-1:0] width_reg;
  logic [CoordW-1:0] height_reg;

  rgb_t pixel_q[$];
  int   mismatch_cnt;
  int   pixels_seen;
  bit   idle_on;
  int   stall_left;
  rgb_t got_rgb;
  rgb_t want_rgb;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit
  initial begin
    #15ms;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) $display("mismatch: %s", msg);
  endfunction

  // rebuild every curve from its anchors at 4n+1
  function automatic void fill_all_curves();
    int a;
    int d;
    for (int t = 0; t < NumTables; t++) begin
      for (int c = 0; c < NumChan; c++) begin
        for (int i = FirstAnchor; i < LastAnchor; i += AnchorStep) begin
          a = int'(curve_mem[t][c][i]);
          d = int'(curve_mem[t][c][i + AnchorStep]) - a;
          for (int m = 1; m < AnchorStep; m++)
            curve_mem[t][c][i + m] = ValW'(a + (m * d) / AnchorStep);
        end
        curve_mem[t][c][254] = curve_mem[t][c][LastAnchor];
        curve_mem[t][c][255] = curve_mem[t][c][LastAnchor];
        curve_mem[t][c][0]   = curve_mem[t][c][1];
      end
    end
  endfunction

  // one lookup stage; skipped for zero size or a stripe past the tables
  function automatic rgb_t curve_stage(input int unsigned coord, input int unsigned size,
                                       input rgb_t px_in);
    rgb_t        px;
    int unsigned t;
    px = px_in;
    if (size != 0) begin
      t = coord / size;
      if (t < NumTables) begin
        for (int c = 0; c < NumChan; c++) px[c] = curve_mem[t][c][px_in[c]];
      end
    end
    return px;
  endfunction

  function automatic bit is_ignored(input beat_t b);
    return (b.kind == KIND_UNUSED) ||
           (b.kind == OP_ANCHOR && (b.table_sel >= NumTables || b.chan == CHAN_NONE));
  endfunction

  // update shadow state for an accepted beat and queue the expected pixel
  function automatic void predict_beat(input beat_t b);
    rgb_t px;
    if (!is_ignored(b)) begin
      case (b.kind)
        OP_ANCHOR: curve_mem[b.table_sel][b.chan][b.key] = b.value;
        OP_FILL:   fill_all_curves();
        OP_PIXEL: begin
          px = curve_stage(b.col, width_reg, b.rgb);
          px = curve_stage(b.row, height_reg, px);
          pixel_q.push_back(px);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.kind      = 2'($urandom);
    b.table_sel = TableW'($urandom);
    b.chan      = ChanW'($urandom);
    b.key       = KeyW'($urandom);
    b.value     = ValW'($urandom);
    b.row       = CoordW'($urandom);
    b.col       = CoordW'($urandom);
    b.rgb       = rgb_t'($urandom);
    return b;
  endfunction

  function automatic beat_t pixel_beat(input int row, input int col,
                                       input int r, input int g, input int bl);
    beat_t b;
    b = noise_beat();
    b.kind = OP_PIXEL;
    b.row  = CoordW'(row);
    b.col  = CoordW'(col);
    b.rgb[ChRed]   = ValW'(r);
    b.rgb[ChGreen] = ValW'(g);
    b.rgb[ChBlue]  = ValW'(bl);
    return b;
  endfunction

  function automatic beat_t anchor_beat(input int t, input int c, input int key, input int val);
    beat_t b;
    b = noise_beat();
    b.kind      = OP_ANCHOR;
    b.table_sel = TableW'(t);
    b.chan      = ChanW'(c);
    b.key       = KeyW'(key);
    b.value     = ValW'(val);
    return b;
  endfunction

  function automatic beat_t kind_beat(input logic [1:0] kind);
    beat_t b;
    b = noise_beat();
    b.kind = kind;
    return b;
  endfunction

  // coordinate mostly inside the six stripes, sometimes anywhere
  function automatic logic [CoordW-1:0] pick_coord(input int unsigned size);
    int unsigned span;
    if (size == 0 || $urandom_range(0, 3) == 0) return CoordW'($urandom_range(0, 1023));
    span = NumTables * size - 1;
    if (span > 1023) span = 1023;
    return CoordW'($urandom_range(0, span));
  endfunction

  function automatic beat_t random_beat(input int unsigned w, input int unsigned h);
    beat_t       b;
    int unsigned r;
    b = noise_beat();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      b.kind = OP_PIXEL;
      b.col  = pick_coord(w);
      b.row  = pick_coord(h);
    end else if (r < 88) begin
      b.kind      = OP_ANCHOR;
      b.table_sel = TableW'($urandom_range(0, NumTables - 1));
      b.chan      = ChanW'($urandom_range(0, NumChan - 1));
      if ($urandom_range(0, 3) == 0) b.value = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end else if (r < 90) begin
      b.kind = OP_FILL;
    end else if (r < 95) begin
      // write to a table or channel that does not exist
      b.kind = OP_ANCHOR;
      if ($urandom_range(0, 1)) b.table_sel = TableW'($urandom_range(NumTables, 7));
      else b.chan = CHAN_NONE;
    end else begin
      b.kind = KIND_UNUSED;
    end
    return b;
  endfunction

  // drive one beat, wait for the handshake, then predict
  task automatic send_beat(input beat_t b);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_bus.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    item_bus.kind        = b.kind;
    item_bus.table_sel   = b.table_sel;
    item_bus.channel_sel = b.chan;
    item_bus.entry_key   = b.key;
    item_bus.entry_value = b.value;
    item_bus.pixel_row   = b.row;
    item_bus.pixel_col   = b.col;
    item_bus.red_in      = b.rgb[ChRed];
    item_bus.green_in    = b.rgb[ChGreen];
    item_bus.blue_in     = b.rgb[ChBlue];
    item_bus.valid       = 1'b1;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    predict_beat(b);
  endtask

  // stop sending, wait for every pending pixel, then let the block go quiet
  task automatic settle_block(input int extra);
    @(negedge clk_i);
    item_bus.valid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_stripes(input int w, input int h);
    settle_block(FillGuard);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_STRIPE_WIDTH;
    cfg_data_i = CfgDataW'(w);
    @(negedge clk_i);
    cfg_idx_i  = CFG_STRIPE_HEIGHT;
    cfg_data_i = CfgDataW'(h);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    width_reg  = CoordW'(w);
    height_reg = CoordW'(h);
  endtask

  task automatic run_random(input int w, input int h, input int n);
    beat_t b;
    int    done;
    write_stripes(w, h);
    done = 0;
    while (done < n) begin
      b = random_beat(w, h);
      if (!is_ignored(b)) done++;
      send_beat(b);
    end
  endtask

  // curves are unwritten here: only pixels past every stripe, and ignored beats
  task automatic test_passthrough();
    send_beat(pixel_beat(1023, 1023, 0, 255, 0));
    send_beat(pixel_beat(450, 600, 255, 0, 255));
    send_beat(anchor_beat(NumTables, 0, 1, 9));
    send_beat(anchor_beat(7, 2, 5, 9));
    send_beat(anchor_beat(0, CHAN_NONE, 1, 9));
    send_beat(kind_beat(KIND_UNUSED));
    send_beat(pixel_beat(1023, 600, 1, 128, 254));
  endtask

  // every anchor of every curve, then a rebuild, so no lookup reads unwritten data
  task automatic test_load_curves();
    int val;
    for (int t = 0; t < NumTables; t++) begin
      for (int c = 0; c < NumChan; c++) begin
        for (int i = FirstAnchor; i <= LastAnchor; i += AnchorStep) begin
          if (t == 0 && c == ChRed) val = ((i / AnchorStep) % 2) ? 255 : 0;
          else if (t == 1 && c == ChGreen) val = i;
          else if (t == NumTables - 1 && c == ChBlue) val = 255 - i;
          else val = $urandom_range(0, 255);
          send_beat(anchor_beat(t, c, i, val));
        end
      end
    end
    send_beat(kind_beat(OP_FILL));
  endtask

  // lookups at table edges and stripe boundaries with reset stripe sizes
  task automatic test_directed_lookup();
    send_beat(pixel_beat(0, 0, 0, 255, 254));
    send_beat(pixel_beat(449, 599, 255, 0, 1));
    send_beat(pixel_beat(74, 99, 253, 2, 3));
    send_beat(pixel_beat(75, 100, 4, 5, 252));
    send_beat(pixel_beat(0, 1023, 128, 127, 255));
    send_beat(pixel_beat(1023, 0, 0, 0, 0));
    // direct write of a non-anchor entry is visible until the next rebuild
    send_beat(anchor_beat(0, ChRed, 2, 77));
    send_beat(pixel_beat(1023, 0, 2, 2, 2));
    send_beat(kind_beat(OP_FILL));
    send_beat(pixel_beat(1023, 0, 2, 2, 2));
  endtask

  // zero stripe size skips its stage
  task automatic test_zero_stripe();
    write_stripes(0, 0);
    send_beat(pixel_beat(0, 0, 17, 200, 255));
    write_stripes(0, 75);
    send_beat(pixel_beat(10, 0, 17, 200, 0));
    write_stripes(100, 0);
    send_beat(pixel_beat(0, 10, 17, 200, 0));
  endtask

  task automatic test_stripe_sweep();
    run_random(1, 1, 40);
    run_random(1023, 1023, 40);
    run_random(0, $urandom_range(1, 200), 20);
    run_random($urandom_range(1, 200), 0, 20);
    run_random($urandom_range(1, 200), $urandom_range(1, 200), 50);
    run_random($urandom_range(1, 1023), $urandom_range(1, 200), 50);
    run_random(171, 1, 40);
    run_random(100, 75, 50);
  endtask

  // last stretch at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    run_random($urandom_range(50, 170), $urandom_range(50, 170), 100);
  endtask

  // result ready with random stall bursts
  always @(negedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      result_bus.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_bus.ready = 1'b0;
    end else begin
      result_bus.ready = 1'b1;
      if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 19);
    end
  end

  // compare each result beat with the oldest expected pixel
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      got_rgb[ChRed]   = result_bus.red_out;
      got_rgb[ChGreen] = result_bus.green_out;
      got_rgb[ChBlue]  = result_bus.blue_out;
      if (pixel_q.size() == 0) begin
        note_mismatch($sformatf("result beat with no pixel pending, got %0d/%0d/%0d",
                                got_rgb[ChRed], got_rgb[ChGreen], got_rgb[ChBlue]));
      end else begin
        want_rgb = pixel_q.pop_front();
        for (int c = 0; c < NumChan; c++) begin
          if (got_rgb[c] !== want_rgb[c])
            note_mismatch($sformatf("pixel %0d %s exp %0d got %0d", pixels_seen,
                                    (c == ChRed) ? "red" : (c == ChGreen) ? "green" : "blue",
                                    want_rgb[c], got_rgb[c]));
        end
      end
      pixels_seen++;
    end
  end

  initial begin
    mismatch_cnt = 0;
    pixels_seen  = 0;
    idle_on      = 1'b1;
    stall_left   = 0;
    width_reg    = StripeWidthRst;
    height_reg   = StripeHeightRst;
    for (int t = 0; t < NumTables; t++)
      for (int c = 0; c < NumChan; c++)
        for (int k = 0; k < CurveEntries; k++) curve_mem[t][c][k] = '0;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_STRIPE_WIDTH;
    cfg_data_i             = '0;
    item_bus.valid         = 1'b0;
    item_bus.kind          = OP_ANCHOR;
    item_bus.table_sel     = '0;
    item_bus.channel_sel   = '0;
    item_bus.entry_key     = '0;
    item_bus.entry_value   = '0;
    item_bus.pixel_row     = '0;
    item_bus.pixel_col     = '0;
    item_bus.red_in        = '0;
    item_bus.green_in      = '0;
    item_bus.blue_in       = '0;
    result_bus.ready       = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_passthrough();
    test_load_curves();
    test_directed_lookup();
    test_zero_stripe();
    test_stripe_sweep();
    test_full_rate();

    settle_block(FillGuard);
    if (mismatch_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
